FILE: design/vru_pkg.sv
// Package for the vector refraction unit: fixed-point widths, rounding
// constants and the word types shared by the pipeline modules.
// No dependencies.
`default_nettype none

package vru_pkg;

	localparam int VEC_FRAC_BITS   = 14;
	localparam int VEC_W           = 16;
	localparam int RATIO_W         = 16;
	localparam int RATIO_FRAC_BITS = 12;
	localparam int OUT_W           = 20;

	localparam int IN_TDATA_W  = ((7 * VEC_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((3 * OUT_W + 7) / 8) * 8;

	// dot product, cosine, c*n, inner sum, ratio product, perp
	localparam int DOT_W      = 2 * VEC_W + 1;
	localparam int C_W        = DOT_W - VEC_FRAC_BITS;
	localparam int PROD_CN_W  = C_W + VEC_W;
	localparam int INNER_W    = PROD_CN_W - VEC_FRAC_BITS + 1;
	localparam int PROD_RI_W  = INNER_W + RATIO_W + 1;
	localparam int P_W        = PROD_RI_W - RATIO_FRAC_BITS;

	// squared length and root
	localparam int MAG_W       = P_W;
	localparam int SQ_W        = 2 * MAG_W + 2;
	localparam int ROOT_W      = SQ_W / 2;
	localparam int REM_W       = ROOT_W + 3;
	localparam int SQRT_STEPS  = 2;
	localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

	// parallel part and final sum
	localparam int PROD_RN_W = ROOT_W + 1 + VEC_W;
	localparam int SUM_W     = PROD_RN_W - VEC_FRAC_BITS + 2;

	localparam int FRONT_STAGES = 8;
	localparam int PIPE_DEPTH   = FRONT_STAGES + SQRT_STAGES + 1;

	localparam logic signed [DOT_W-1:0] DOT_ONE  = DOT_W'(1) <<< (2 * VEC_FRAC_BITS);
	localparam logic signed [DOT_W-1:0] DOT_HALF = DOT_W'(1) <<< (VEC_FRAC_BITS - 1);
	localparam logic signed [PROD_CN_W-1:0] CN_HALF =
		PROD_CN_W'(1) <<< (VEC_FRAC_BITS - 1);
	localparam logic signed [PROD_RI_W-1:0] RI_HALF =
		PROD_RI_W'(1) <<< (RATIO_FRAC_BITS - 1);
	localparam logic signed [PROD_RN_W-1:0] RN_HALF =
		PROD_RN_W'(1) <<< (VEC_FRAC_BITS - 1);
	localparam logic [SQ_W-1:0] SQ_ONE = SQ_W'(1) << (2 * VEC_FRAC_BITS);
	localparam logic signed [SUM_W-1:0] SUM_OUT_MAX = SUM_W'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] SUM_OUT_MIN = -SUM_OUT_MAX - SUM_W'(1);

	typedef logic [2:0][VEC_W-1:0] vec3_t;
	typedef logic [2:0][P_W-1:0]   perp3_t;

	typedef struct packed {
		vec3_t  norm;
		perp3_t perp;
	} carry_t;

	typedef struct packed {
		logic [SQ_W-1:0]   rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] z;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] x;
	} res_t;

	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > SUM_OUT_MAX)
			r = SUM_OUT_MAX[OUT_W-1:0];
		else if (v < SUM_OUT_MIN)
			r = SUM_OUT_MIN[OUT_W-1:0];
		else
			r = v[OUT_W-1:0];
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/vector_refraction_unit_top.sv
// Each word passes the front, sqrt, back and output registers to m_axis.
// Throughput: one word per cycle, set by the fully pipelined datapath; the
// square root runs as a chain of stages of two digit steps each.
// The whole pipeline advances on one enable that drops only while the skid
// slot holds a word. arst_n clears all valid bits and the output stage.
`default_nettype none

module vector_refraction_unit_top import vru_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio (16 bits each)
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// out_x, out_y, out_z (20 bits each), zero fill
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic        en;
	logic        front_valid;
	logic [SQ_W-1:0] diff;
	carry_t      front_carry;

	logic   sq_valid [SQRT_STAGES+1];
	sqrt_t  sq_chain [SQRT_STAGES+1];
	carry_t sq_carry [SQRT_STAGES+1];

	logic back_valid;
	res_t back_res;
	res_t out_res;

	vru_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.dir       (s_axis_tdata[3*VEC_W-1:0]),
		.norm      (s_axis_tdata[6*VEC_W-1:3*VEC_W]),
		.ratio     (s_axis_tdata[6*VEC_W+RATIO_W-1:6*VEC_W]),
		.out_valid (front_valid),
		.diff      (diff),
		.carry     (front_carry)
	);

	assign sq_valid[0]      = front_valid;
	assign sq_chain[0].rad  = diff;
	assign sq_chain[0].rem  = '0;
	assign sq_chain[0].root = '0;
	assign sq_carry[0]      = front_carry;

	for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
		vru_sqrt_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (sq_valid[g]),
			.in_sq     (sq_chain[g]),
			.in_carry  (sq_carry[g]),
			.out_valid (sq_valid[g+1]),
			.out_sq    (sq_chain[g+1]),
			.out_carry (sq_carry[g+1])
		);
	end

	vru_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid[SQRT_STAGES]),
		.root      (sq_chain[SQRT_STAGES].root),
		.carry     (sq_carry[SQRT_STAGES]),
		.out_valid (back_valid),
		.res       (back_res)
	);

	vru_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (back_valid),
		.in_data   (back_res),
		.in_ready  (en),
		.out_valid (m_axis_tvalid),
		.out_data  (out_res),
		.out_ready (m_axis_tready)
	);

	assign s_axis_tready = en;
	assign m_axis_tdata  = OUT_TDATA_W'(out_res);

endmodule

`default_nettype wire

FILE: design/vru_front.sv
// Front pipeline of the refraction unit: cosine, perpendicular part,
// squared length and |1 - |perp|^2| over eight register stages.
// Depends on vru_pkg.
`default_nettype none

module vru_front import vru_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  vec3_t               dir,
	input  vec3_t               norm,
	input  logic [RATIO_W-1:0]  ratio,
	output logic                out_valid,
	output logic [SQ_W-1:0]     diff,
	output carry_t              carry
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic signed [2*VEC_W-1:0]   dn_s1 [3];
	logic signed [C_W-1:0]       c_s2;
	logic signed [PROD_CN_W-1:0] cn_s3 [3];
	logic signed [INNER_W-1:0]   inner_s4 [3];
	logic signed [PROD_RI_W-1:0] ri_s5 [3];
	perp3_t                      perp_s6, perp_s7, perp_s8;
	logic [2*MAG_W-1:0]          sq_s7 [3];
	logic [SQ_W-1:0]             diff_s8;

	vec3_t dir_s1, dir_s2, dir_s3;
	vec3_t norm_s1, norm_s2, norm_s3, norm_s4, norm_s5, norm_s6, norm_s7, norm_s8;
	logic [RATIO_W-1:0] ratio_s1, ratio_s2, ratio_s3, ratio_s4;

	logic signed [2*VEC_W-1:0]   dn_d [3];
	logic signed [C_W-1:0]       c_d;
	logic signed [PROD_CN_W-1:0] cn_d [3];
	logic signed [INNER_W-1:0]   inner_d [3];
	logic signed [PROD_RI_W-1:0] ri_d [3];
	perp3_t                      perp_d;
	logic [2*MAG_W-1:0]          sq_d [3];
	logic [SQ_W-1:0]             diff_d;

	always_comb begin
		logic signed [DOT_W-1:0]     dot_c, dot_k, dot_r;
		logic signed [PROD_CN_W-1:0] cn_r;
		logic signed [PROD_RI_W-1:0] ri_r;
		logic signed [P_W-1:0]       p;
		logic [MAG_W-1:0]            mag;
		logic [SQ_W-1:0]             sum;
		dot_c = '0;
		for (int i = 0; i < 3; i++) begin
			dn_d[i] = $signed(dir[i]) * $signed(norm[i]);
			dot_c   = dot_c - DOT_W'(dn_s1[i]);
		end
		dot_k = (dot_c > DOT_ONE) ? DOT_ONE : dot_c;
		dot_r = dot_k + DOT_HALF;
		c_d   = dot_r[DOT_W-1:VEC_FRAC_BITS];
		sum   = '0;
		for (int i = 0; i < 3; i++) begin
			cn_d[i]    = PROD_CN_W'(c_s2) * PROD_CN_W'($signed(norm_s2[i]));
			cn_r       = cn_s3[i] + CN_HALF;
			inner_d[i] = INNER_W'($signed(dir_s3[i])) +
				INNER_W'($signed(cn_r[PROD_CN_W-1:VEC_FRAC_BITS]));
			ri_d[i]    = PROD_RI_W'(inner_s4[i]) *
				PROD_RI_W'($signed({1'b0, ratio_s4}));
			ri_r       = ri_s5[i] + RI_HALF;
			perp_d[i]  = ri_r[PROD_RI_W-1:RATIO_FRAC_BITS];
			p          = $signed(perp_s6[i]);
			mag        = (p < 0) ? MAG_W'(-p) : MAG_W'(p);
			sq_d[i]    = (2*MAG_W)'(mag) * (2*MAG_W)'(mag);
			sum        = sum + SQ_W'(sq_s7[i]);
		end
		diff_d = (sum >= SQ_ONE) ? (sum - SQ_ONE) : (SQ_ONE - sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dn_s1    <= dn_d;
			dir_s1   <= dir;
			norm_s1  <= norm;
			ratio_s1 <= ratio;
			c_s2     <= c_d;
			dir_s2   <= dir_s1;
			norm_s2  <= norm_s1;
			ratio_s2 <= ratio_s1;
			cn_s3    <= cn_d;
			dir_s3   <= dir_s2;
			norm_s3  <= norm_s2;
			ratio_s3 <= ratio_s2;
			inner_s4 <= inner_d;
			norm_s4  <= norm_s3;
			ratio_s4 <= ratio_s3;
			ri_s5    <= ri_d;
			norm_s5  <= norm_s4;
			perp_s6  <= perp_d;
			norm_s6  <= norm_s5;
			sq_s7    <= sq_d;
			perp_s7  <= perp_s6;
			norm_s7  <= norm_s6;
			diff_s8  <= diff_d;
			perp_s8  <= perp_s7;
			norm_s8  <= norm_s7;
		end
	end

	assign out_valid  = v_s8;
	assign diff       = diff_s8;
	assign carry.norm = norm_s8;
	assign carry.perp = perp_s8;

endmodule

`default_nettype wire

FILE: design/vru_sqrt_stage.sv
// One stage of the pipelined integer square root: two restoring
// digit steps per register, side payload carried alongside.
// Depends on vru_pkg.
`default_nettype none

module vru_sqrt_stage import vru_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   in_valid,
	input  sqrt_t  in_sq,
	input  carry_t in_carry,
	output logic   out_valid,
	output sqrt_t  out_sq,
	output carry_t out_carry
);

	logic   v_s1;
	sqrt_t  sq_s1;
	carry_t carry_s1;
	sqrt_t  sq_d;

	always_comb begin
		logic [REM_W-1:0] rem_sh, trial;
		sq_d = in_sq;
		for (int k = 0; k < SQRT_STEPS; k++) begin
			rem_sh   = {sq_d.rem[REM_W-3:0], sq_d.rad[SQ_W-1:SQ_W-2]};
			trial    = {1'b0, sq_d.root, 2'b01};
			sq_d.rad = {sq_d.rad[SQ_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				sq_d.rem  = rem_sh - trial;
				sq_d.root = {sq_d.root[ROOT_W-2:0], 1'b1};
			end else begin
				sq_d.rem  = rem_sh;
				sq_d.root = {sq_d.root[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1    <= sq_d;
			carry_s1 <= in_carry;
		end
	end

	assign out_valid = v_s1;
	assign out_sq    = sq_s1;
	assign out_carry = carry_s1;

endmodule

`default_nettype wire

FILE: design/vru_back.sv
// Back stage of the refraction unit: root times normal, rounding, and the
// saturated difference of the perpendicular and parallel parts.
// Depends on vru_pkg.
`default_nettype none

module vru_back import vru_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [ROOT_W-1:0] root,
	input  carry_t            carry,
	output logic              out_valid,
	output res_t              res
);

	logic                        v_s1;
	logic signed [PROD_RN_W-1:0] rn_s1 [3];
	perp3_t                      perp_s1;
	logic signed [PROD_RN_W-1:0] rn_d [3];
	logic signed [OUT_W-1:0]     r [3];

	always_comb begin
		logic signed [PROD_RN_W-1:0] rn_r;
		logic signed [SUM_W-1:0]     s;
		for (int i = 0; i < 3; i++) begin
			rn_d[i] = PROD_RN_W'($signed({1'b0, root})) *
				PROD_RN_W'($signed(carry.norm[i]));
			rn_r    = rn_s1[i] + RN_HALF;
			s       = SUM_W'($signed(perp_s1[i])) -
				SUM_W'($signed(rn_r[PROD_RN_W-1:VEC_FRAC_BITS]));
			r[i]    = sat_out(s);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rn_s1   <= rn_d;
			perp_s1 <= carry.perp;
		end
	end

	assign out_valid = v_s1;
	assign res.x     = r[0];
	assign res.y     = r[1];
	assign res.z     = r[2];

endmodule

`default_nettype wire

FILE: design/vru_skid.sv
// Output register with a skid slot; parts the pipeline from the stream
// sink; a waiting result stalls the pipeline once the skid slot fills.
// Depends on vru_pkg.
`default_nettype none

module vru_skid import vru_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  res_t in_data,
	output logic in_ready,
	output logic out_valid,
	output res_t out_data,
	input  logic out_ready
);

	logic out_valid_q, skid_valid_q;
	res_t out_data_q, skid_data_q;
	logic load_out;

	assign load_out = out_ready || !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		else if (in_valid && !skid_valid_q)
			skid_data_q <= in_data;
	end

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

FILE: design/vru_checker.sv
// Port-level checker for the refraction unit, bound to the top level.
// Depends on vru_pkg and vector_refraction_unit_top.
`default_nettype none

module vru_checker import vru_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int CAP   = PIPE_DEPTH + 2;
	localparam int CNT_W = $clog2(CAP + 2);

	logic [CNT_W-1:0] cnt_q;
	logic s_acc, m_acc;

	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign m_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (s_acc && !m_acc)
			cnt_q <= cnt_q + CNT_W'(1);
		else if (m_acc && !s_acc)
			cnt_q <= cnt_q - CNT_W'(1);
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> cnt_q != '0)
		else $error("result word without an outstanding input word");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAP))
		else $error("more words in flight than the pipeline holds");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !$past(m_axis_tready))
		else $error("input stalled without a waiting result");

endmodule

bind vector_refraction_unit_top vru_checker u_vru_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: test/refraction_checker.sv
// Scoreboard for the vector refraction unit: predicts each refracted word from
// the accepted input word and compares it field by field with the output stream.
// Depends on vru_pkg for widths and the result word layout.
module refraction_checker import vru_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_valid,
	input  logic                   s_ready,
	input  logic [IN_TDATA_W-1:0]  s_data,
	input  logic                   m_valid,
	input  logic                   m_ready,
	input  logic [OUT_TDATA_W-1:0] m_data,
	output int                     errors,
	output int                     pending,
	output int                     checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint UNIT_SQ = longint'(1) <<< (2 * VEC_FRAC_BITS);
	localparam longint PERP_HI = 64'sh7FFF_FFFF;
	localparam longint PERP_LO = -PERP_HI - 1;
	localparam longint OUT_HI  = (longint'(1) <<< (OUT_W - 1)) - 1;
	localparam longint OUT_LO  = -OUT_HI - 1;

	res_t refracted_q[$];
	res_t got, want;
	int   err_cnt = 0;
	int   match_cnt = 0;

	assign errors  = err_cnt;
	assign pending = refracted_q.size();
	assign checked = match_cnt;

	// round half up: floor((v + 2^(s-1)) / 2^s)
	function automatic longint round_half_up(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned rem, root, digit;
		rem = v;
		root = 0;
		digit = 64'd1 << 62;
		while (digit > rem)
			digit >>= 2;
		while (digit != 0) begin
			if (rem >= root + digit) begin
				rem -= root + digit;
				root = (root >> 1) + digit;
			end else begin
				root >>= 1;
			end
			digit >>= 2;
		end
		return root;
	endfunction

	function automatic res_t refract_predict(input logic [IN_TDATA_W-1:0] w);
		longint dir_v[3], norm_v[3], perp_v[3], out_v[3];
		longint dotp, cosv, ratio, inner;
		longint unsigned mag, sq, diff, root;
		res_t r;
		dotp = 0;
		sq = 0;
		ratio = longint'(w[6*VEC_W +: RATIO_W]);
		for (int i = 0; i < 3; i++) begin
			dir_v[i]  = longint'($signed(w[i*VEC_W +: VEC_W]));
			norm_v[i] = longint'($signed(w[(3+i)*VEC_W +: VEC_W]));
			dotp -= dir_v[i] * norm_v[i];
		end
		if (dotp > UNIT_SQ)
			dotp = UNIT_SQ;
		cosv = round_half_up(dotp, VEC_FRAC_BITS);
		for (int i = 0; i < 3; i++) begin
			inner = dir_v[i] + round_half_up(cosv * norm_v[i], VEC_FRAC_BITS);
			perp_v[i] = clamp(round_half_up(ratio * inner, RATIO_FRAC_BITS), PERP_LO, PERP_HI);
			mag = (perp_v[i] < 0) ? -perp_v[i] : perp_v[i];
			sq += mag * mag;
		end
		diff = (sq >= UNIT_SQ) ? sq - UNIT_SQ : UNIT_SQ - sq;
		root = floor_sqrt(diff);
		for (int i = 0; i < 3; i++)
			out_v[i] = clamp(perp_v[i] - round_half_up(longint'(root) * norm_v[i],
				VEC_FRAC_BITS), OUT_LO, OUT_HI);
		r.x = out_v[0][OUT_W-1:0];
		r.y = out_v[1][OUT_W-1:0];
		r.z = out_v[2][OUT_W-1:0];
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [OUT_W-1:0] exp_v,
		input logic [OUT_W-1:0] act_v);
		if (act_v !== exp_v) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %0d (%h), actual %0d (%h)", $time, name,
				$signed(exp_v), exp_v, $signed(act_v), act_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_valid && s_ready)
				refracted_q.push_back(refract_predict(s_data));
			if (m_valid && m_ready) begin
				got = res_t'(m_data[3*OUT_W-1:0]);
				if (refracted_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected word, expected none, actual %h", $time, got);
				end else begin
					want = refracted_q.pop_front();
					match_cnt++;
					compare_field("out_x", want.x, got.x);
					compare_field("out_y", want.y, got.y);
					compare_field("out_z", want.z, got.z);
				end
			end
		end
	end

endmodule

FILE: test/tb_vector_refraction_unit_top.sv
// Testbench top for the vector refraction unit: drives directed and random
// refraction words under varying flow control and reports the verdict.
// Depends on vru_pkg, vector_refraction_unit_top and refraction_checker.
module tb_vector_refraction_unit_top;
	timeunit 1ns;
	timeprecision 1ps;

	import vru_pkg::*;

	localparam int DIRECTED_N = 15;
	localparam int RANDOM_N   = 800;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_valid = 1'b0;
	logic                   s_ready;
	logic [IN_TDATA_W-1:0]  s_data = '0;
	logic                   m_valid;
	logic                   m_ready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_data;
	int                     tx_idle_pct = 0;
	int                     rx_idle_pct = 0;
	int                     errors, pending, checked;
	int                     wait_n;

	vector_refraction_unit_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data)
	);

	refraction_checker checker_i (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_valid),
		.s_ready (s_ready),
		.s_data  (s_data),
		.m_valid (m_valid),
		.m_ready (m_ready),
		.m_data  (m_data),
		.errors  (errors),
		.pending (pending),
		.checked (checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		m_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	function automatic logic [IN_TDATA_W-1:0] item_word(input int dx, input int dy,
		input int dz, input int nx, input int ny, input int nz, input int eta);
		return {16'(eta), 16'(nz), 16'(ny), 16'(nx), 16'(dz), 16'(dy), 16'(dx)};
	endfunction

	function automatic logic [3*VEC_W-1:0] unit_vec();
		real v[3];
		real len;
		logic [3*VEC_W-1:0] w;
		len = 0.0;
		for (int i = 0; i < 3; i++) begin
			v[i] = real'(int'($urandom_range(20000)) - 10000);
			len += v[i] * v[i];
		end
		if (len == 0.0) begin
			v[2] = 1.0;
			len = 1.0;
		end
		len = $sqrt(len);
		for (int i = 0; i < 3; i++)
			w[i*VEC_W +: VEC_W] = 16'($rtoi(v[i] / len * 16384.0 + ((v[i] < 0.0) ? -0.5 : 0.5)));
		return w;
	endfunction

	task automatic send_word(input logic [IN_TDATA_W-1:0] w);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_valid <= 1'b0;
			@(posedge clk);
		end
		s_valid <= 1'b1;
		s_data <= w;
		@(posedge clk);
		while (!s_ready)
			@(posedge clk);
	endtask

	task automatic run_phase(input int tx_pct, input int rx_pct, input int count);
		logic [3*VEC_W-1:0] dir_w, norm_w;
		logic [RATIO_W-1:0] eta;
		int dot;
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(9) < 3) begin
				send_word(IN_TDATA_W'({$urandom, $urandom, $urandom, $urandom}));
			end else begin
				norm_w = unit_vec();
				dir_w = unit_vec();
				dot = 0;
				for (int i = 0; i < 3; i++)
					dot += int'($signed(dir_w[i*VEC_W +: VEC_W])) *
						int'($signed(norm_w[i*VEC_W +: VEC_W]));
				// turn most rays toward the surface
				if (dot > 0 && $urandom_range(3) != 0)
					for (int i = 0; i < 3; i++)
						dir_w[i*VEC_W +: VEC_W] = -dir_w[i*VEC_W +: VEC_W];
				eta = $urandom_range(1) ? 16'($urandom_range(2048, 8192)) : 16'($urandom);
				send_word({eta, norm_w, dir_w});
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_pct = 14;
		rx_idle_pct <= 65;

		send_word(item_word(0, 0, 0, 0, 0, 0, 0));
		send_word(item_word(0, 0, -16384, 0, 0, 16384, 16'h1000));
		send_word(item_word(0, 0, -16384, 0, 0, 16384, 0));
		send_word(item_word(11585, 0, -11585, 0, 0, 16384, 16'h1800));
		send_word(item_word(11585, 0, -11585, 0, 0, 16384, 16'h0AAB));
		send_word(item_word(0, 0, -32768, 0, 0, 32767, 16'h1000));
		send_word(item_word(0, 0, 16384, 0, 0, 16384, 16'h1000));
		send_word(item_word(-32768, -32768, -32768, -32768, -32768, -32768, 16'hFFFF));
		send_word(item_word(32767, 32767, 32767, -32768, -32768, -32768, 16'hFFFF));
		send_word(item_word(32767, 32767, 32767, 32767, 32767, 32767, 16'hFFFF));
		send_word(item_word(-32768, 32767, -32768, 32767, -32768, 32767, 16'h8000));
		send_word(item_word(16384, 0, 0, -16384, 0, 0, 16'h0001));
		send_word(item_word(9459, 9459, -9459, 0, 16384, 0, 16'h1000));
		send_word(item_word(0, -16384, 0, 0, 16384, 0, 16'hFFFF));
		send_word(item_word(1, 1, 1, 0, 0, 0, 16'hFFFF));

		run_phase(14, 65, 270);
		run_phase(65, 14, 270);
		run_phase(0, 0, RANDOM_N - 540);
		s_valid <= 1'b0;

		wait_n = 0;
		while (pending != 0 && wait_n < 100000) begin
			@(negedge clk);
			wait_n++;
		end
		repeat (64) @(negedge clk);

		if (pending != 0)
			$display("%0d refracted words never arrived", pending);
		$display("Sent %0d directed and %0d random refraction words across three flow-control mixes;",
			DIRECTED_N, RANDOM_N);
		$display("%0d output words compared, %0d field mismatches.", checked, errors);
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: vector_refraction_unit_top.f
design/vru_pkg.sv
design/vru_front.sv
design/vru_sqrt_stage.sv
design/vru_back.sv
design/vru_skid.sv
design/vector_refraction_unit_top.sv
design/vru_checker.sv
test/refraction_checker.sv
test/tb_vector_refraction_unit_top.sv
